/* src/awmt_pkg.sv */
// Shared types and status codes for the address window merge table.
package awmt_pkg;

   localparam int ADDR_W   = 64;
   localparam int FLAGS_W  = 32;
   localparam int STATUS_W = 3;
   localparam int INDEX_W  = 4;
   localparam int USED_W   = 5;

   localparam logic [STATUS_W-1:0] ST_MERGED   = 3'd0;
   localparam logic [STATUS_W-1:0] ST_APPENDED = 3'd1;
   localparam logic [STATUS_W-1:0] ST_INVALID  = 3'd2;
   localparam logic [STATUS_W-1:0] ST_FULL     = 3'd3;
   localparam logic [STATUS_W-1:0] ST_READ_OK  = 3'd4;
   localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd5;

   localparam logic OP_UPDATE = 1'b0;
   localparam logic OP_READ   = 1'b1;

   typedef struct packed {
      logic [ADDR_W-1:0]  win_start;
      logic [ADDR_W-1:0]  win_end;
      logic [FLAGS_W-1:0] flags;
   } entry_type;

endpackage

/* src/address_window_merge_table_core.sv */
// Address window table with merge-on-update, scanned by a single compare unit.
// The scan reads one table entry per cycle from the entry RAM and tests it in the shared
// adjacency/overlap compare; busy stays high until the result is written to the outputs.
// The result is shown for one cycle and cannot be stalled. Synchronous reset empties the
// table (entry count to zero); the entry RAM itself is not cleared.
module address_window_merge_table_core
   import awmt_pkg::*;
#(
   parameter int TABLE_ENTRIES = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic                req_opcode,
   input  logic [ADDR_W-1:0]   req_window_start,
   input  logic [ADDR_W-1:0]   req_window_end,
   input  logic [FLAGS_W-1:0]  req_window_flags,
   input  logic                req_allow_merge,
   input  logic [INDEX_W-1:0]  req_read_index,
   output logic                rsp_strobe,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [INDEX_W-1:0]  rsp_entry_index,
   output logic [ADDR_W-1:0]   rsp_entry_start,
   output logic [ADDR_W-1:0]   rsp_entry_end,
   output logic [FLAGS_W-1:0]  rsp_entry_flags,
   output logic [USED_W-1:0]   rsp_entries_used
);

   localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int CW = $clog2(TABLE_ENTRIES + 1);
   localparam int IW = (AW > INDEX_W) ? AW : INDEX_W;
   localparam int RW = (CW > INDEX_W) ? CW : INDEX_W;
   localparam int UW = (CW > USED_W) ? CW : USED_W;
   localparam logic [CW-1:0] FULL_COUNT = CW'(TABLE_ENTRIES);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_CHECK  = 3'd1;
   localparam logic [2:0] S_SCAN   = 3'd2;
   localparam logic [2:0] S_MERGE  = 3'd3;
   localparam logic [2:0] S_APPEND = 3'd4;
   localparam logic [2:0] S_RDOUT  = 3'd5;

   logic [2:0]          state_ff, state_in;
   logic [CW-1:0]       used_ff, used_in;
   logic [CW-1:0]       probe_ff, probe_in;
   logic                eval_valid_ff, eval_valid_in;
   logic [AW-1:0]       eval_idx_ff, eval_idx_in;

   logic                op_ff;
   logic                merge_ff;
   logic [INDEX_W-1:0]  ridx_ff;
   entry_type           req_ff;

   logic                rsp_strobe_ff, rsp_strobe_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [INDEX_W-1:0]  rsp_index_ff, rsp_index_in;
   entry_type           rsp_entry_ff, rsp_entry_in;
   logic [USED_W-1:0]   rsp_used_ff, rsp_used_in;

   entry_type           mem [TABLE_ENTRIES];
   entry_type           rd_data_ff;
   logic                rd_en;
   logic [AW-1:0]       rd_addr;
   logic                wr_en;
   logic [AW-1:0]       wr_addr;
   entry_type           wr_data;

   logic                accept;
   logic                invalid_win;
   logic                ridx_hit;
   logic [IW-1:0]       ridx_ext;
   logic                issue;
   logic                hit;
   logic                touch;
   entry_type           merged;

   function automatic logic [INDEX_W-1:0] index_out(input logic [AW-1:0] idx);
      logic [IW-1:0] wide;
      wide = IW'(idx);
      return wide[INDEX_W-1:0];
   endfunction

   function automatic logic [USED_W-1:0] used_out(input logic [CW-1:0] cnt);
      logic [UW-1:0] wide;
      wide = UW'(cnt);
      return wide[USED_W-1:0];
   endfunction

   assign busy   = (state_ff != S_IDLE);
   assign accept = start && !busy;

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff             <= req_opcode;
         merge_ff          <= req_allow_merge;
         ridx_ff           <= req_read_index;
         req_ff.win_start  <= req_window_start;
         req_ff.win_end    <= req_window_end;
         req_ff.flags      <= req_window_flags;
      end
   end

   // Entry RAM: one write port and one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign invalid_win = (req_ff.win_start > req_ff.win_end) || (&req_ff.win_start);
   assign ridx_ext    = IW'(ridx_ff);
   assign ridx_hit    = RW'(ridx_ff) < RW'(used_ff);
   assign issue       = probe_ff < used_ff;

   // Both windows are well formed, so they overlap or abut exactly when each start
   // lies at most one past the other end. The 65-bit sums keep an end of all ones
   // from wrapping.
   assign touch = ({1'b0, req_ff.win_start} <= ({1'b0, rd_data_ff.win_end} + 65'd1)) &&
                  ({1'b0, rd_data_ff.win_start} <= ({1'b0, req_ff.win_end} + 65'd1));
   assign hit   = eval_valid_ff && (rd_data_ff.flags == req_ff.flags) && touch;

   assign merged.win_start = (req_ff.win_start < rd_data_ff.win_start) ?
                             req_ff.win_start : rd_data_ff.win_start;
   assign merged.win_end   = (req_ff.win_end > rd_data_ff.win_end) ?
                             req_ff.win_end : rd_data_ff.win_end;
   assign merged.flags     = rd_data_ff.flags;

   always_comb begin
      state_in      = state_ff;
      used_in       = used_ff;
      probe_in      = probe_ff;
      eval_valid_in = 1'b0;
      eval_idx_in   = eval_idx_ff;
      rd_en         = 1'b0;
      rd_addr       = probe_ff[AW-1:0];
      wr_en         = 1'b0;
      wr_addr       = eval_idx_ff;
      wr_data       = merged;
      rsp_strobe_in = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_index_in  = rsp_index_ff;
      rsp_entry_in  = rsp_entry_ff;
      rsp_used_in   = rsp_used_ff;

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            if (op_ff == OP_READ) begin
               if (ridx_hit) begin
                  rd_en    = 1'b1;
                  rd_addr  = ridx_ext[AW-1:0];
                  state_in = S_RDOUT;
               end else begin
                  rsp_strobe_in = 1'b1;
                  rsp_status_in = ST_EMPTY;
                  rsp_index_in  = ridx_ff;
                  rsp_entry_in  = '0;
                  rsp_used_in   = used_out(used_ff);
                  state_in      = S_IDLE;
               end
            end else if (invalid_win) begin
               rsp_strobe_in = 1'b1;
               rsp_status_in = ST_INVALID;
               rsp_index_in  = '0;
               rsp_entry_in  = '0;
               rsp_used_in   = used_out(used_ff);
               state_in      = S_IDLE;
            end else if (merge_ff && (used_ff != '0)) begin
               probe_in = '0;
               state_in = S_SCAN;
            end else begin
               state_in = S_APPEND;
            end
         end
         S_SCAN: begin
            // Reads run one entry ahead of the compare; a hit freezes the read data.
            if (issue && !hit) begin
               rd_en         = 1'b1;
               rd_addr       = probe_ff[AW-1:0];
               eval_valid_in = 1'b1;
               eval_idx_in   = probe_ff[AW-1:0];
               probe_in      = probe_ff + CW'(1);
            end
            if (hit) begin
               state_in = S_MERGE;
            end else if (!issue) begin
               state_in = S_APPEND;
            end
         end
         S_MERGE: begin
            wr_en         = 1'b1;
            wr_addr       = eval_idx_ff;
            wr_data       = merged;
            rsp_strobe_in = 1'b1;
            rsp_status_in = ST_MERGED;
            rsp_index_in  = index_out(eval_idx_ff);
            rsp_entry_in  = merged;
            rsp_used_in   = used_out(used_ff);
            state_in      = S_IDLE;
         end
         S_APPEND: begin
            rsp_strobe_in = 1'b1;
            state_in      = S_IDLE;
            if (used_ff >= FULL_COUNT) begin
               rsp_status_in = ST_FULL;
               rsp_index_in  = '0;
               rsp_entry_in  = '0;
               rsp_used_in   = used_out(used_ff);
            end else begin
               wr_en         = 1'b1;
               wr_addr       = used_ff[AW-1:0];
               wr_data       = req_ff;
               used_in       = used_ff + CW'(1);
               rsp_status_in = ST_APPENDED;
               rsp_index_in  = index_out(used_ff[AW-1:0]);
               rsp_entry_in  = req_ff;
               rsp_used_in   = used_out(used_ff + CW'(1));
            end
         end
         S_RDOUT: begin
            rsp_strobe_in = 1'b1;
            rsp_status_in = ST_READ_OK;
            rsp_index_in  = ridx_ff;
            rsp_entry_in  = rd_data_ff;
            rsp_used_in   = used_out(used_ff);
            state_in      = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         used_ff       <= '0;
         eval_valid_ff <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         used_ff       <= used_in;
         eval_valid_ff <= eval_valid_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      probe_ff      <= probe_in;
      eval_idx_ff   <= eval_idx_in;
      rsp_status_ff <= rsp_status_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_entry_ff  <= rsp_entry_in;
      rsp_used_ff   <= rsp_used_in;
   end

   assign rsp_strobe       = rsp_strobe_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_entry_index  = rsp_index_ff;
   assign rsp_entry_start  = rsp_entry_ff.win_start;
   assign rsp_entry_end    = rsp_entry_ff.win_end;
   assign rsp_entry_flags  = rsp_entry_ff.flags;
   assign rsp_entries_used = rsp_used_ff;

   a_strobe_when_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("result shown while an item is still in progress");

   a_accept_goes_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted item did not make the block busy");

   a_used_bounded: assert property (@(posedge clock) disable iff (reset)
      used_ff <= FULL_COUNT)
      else $error("entry count exceeds table size");

   a_used_steps: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && (used_ff != $past(used_ff))) |->
         (used_ff == $past(used_ff) + CW'(1)))
      else $error("entry count changed by other than one append");

endmodule

/* sim/tb_address_window_merge_table_core.sv */
// Self-checking testbench for the address window merge table core.
`timescale 1ns / 100ps

module tb_address_window_merge_table_core
   import awmt_pkg::*;
();

   localparam int TABLE_DEPTH  = 16;
   localparam int DRAIN_CYCLES = 40;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int RANDOM_ITEMS = 700;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [INDEX_W-1:0]  index;
      logic [ADDR_W-1:0]   lo;
      logic [ADDR_W-1:0]   hi;
      logic [FLAGS_W-1:0]  flags;
      logic [USED_W-1:0]   used;
   } table_reply_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                start = 1'b0;
   logic                busy;
   logic                req_opcode = OP_UPDATE;
   logic [ADDR_W-1:0]   req_window_start = '0;
   logic [ADDR_W-1:0]   req_window_end = '0;
   logic [FLAGS_W-1:0]  req_window_flags = '0;
   logic                req_allow_merge = 1'b0;
   logic [INDEX_W-1:0]  req_read_index = '0;
   logic                rsp_strobe;
   logic [STATUS_W-1:0] rsp_status;
   logic [INDEX_W-1:0]  rsp_entry_index;
   logic [ADDR_W-1:0]   rsp_entry_start;
   logic [ADDR_W-1:0]   rsp_entry_end;
   logic [FLAGS_W-1:0]  rsp_entry_flags;
   logic [USED_W-1:0]   rsp_entries_used;

   // Predicted table contents.
   logic [ADDR_W-1:0]  tbl_lo [TABLE_DEPTH];
   logic [ADDR_W-1:0]  tbl_hi [TABLE_DEPTH];
   logic [FLAGS_W-1:0] tbl_flags [TABLE_DEPTH];
   int                 tbl_count = 0;

   table_reply_type pending_replies [$];
   table_reply_type seen_reply;
   table_reply_type oldest_reply;
   int              mismatch_count = 0;
   int              cycle_count = 0;
   int              burst_left = 0;

   address_window_merge_table_core i_dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_opcode       (req_opcode),
      .req_window_start (req_window_start),
      .req_window_end   (req_window_end),
      .req_window_flags (req_window_flags),
      .req_allow_merge  (req_allow_merge),
      .req_read_index   (req_read_index),
      .rsp_strobe       (rsp_strobe),
      .rsp_status       (rsp_status),
      .rsp_entry_index  (rsp_entry_index),
      .rsp_entry_start  (rsp_entry_start),
      .rsp_entry_end    (rsp_entry_end),
      .rsp_entry_flags  (rsp_entry_flags),
      .rsp_entries_used (rsp_entries_used)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   assign seen_reply = {rsp_status, rsp_entry_index, rsp_entry_start, rsp_entry_end,
                        rsp_entry_flags, rsp_entries_used};

   function automatic table_reply_type predict_table_op(input logic op,
                                                        input logic [ADDR_W-1:0] ws,
                                                        input logic [ADDR_W-1:0] we,
                                                        input logic [FLAGS_W-1:0] wf,
                                                        input logic merge,
                                                        input logic [INDEX_W-1:0] ridx);
      table_reply_type   r;
      logic [ADDR_W-1:0] top_start;
      logic [ADDR_W-1:0] low_end;
      r = '0;
      if (op == OP_READ) begin
         r.index = ridx;
         if (ridx < tbl_count) begin
            r.status = ST_READ_OK;
            r.lo     = tbl_lo[ridx];
            r.hi     = tbl_hi[ridx];
            r.flags  = tbl_flags[ridx];
         end else begin
            r.status = ST_EMPTY;
         end
         r.used = USED_W'(tbl_count);
         return r;
      end
      if (ws > we || ws == '1) begin
         r.status = ST_INVALID;
         r.used   = USED_W'(tbl_count);
         return r;
      end
      if (merge) begin
         for (int i = 0; i < tbl_count; i++) begin
            top_start = (tbl_lo[i] > ws) ? tbl_lo[i] : ws;
            low_end   = (tbl_hi[i] < we) ? tbl_hi[i] : we;
            // Abutting is checked as a difference of one, so it never wraps at the top.
            if (tbl_flags[i] == wf && (top_start <= low_end || top_start - low_end == 1)) begin
               if (ws < tbl_lo[i]) tbl_lo[i] = ws;
               if (we > tbl_hi[i]) tbl_hi[i] = we;
               r.status = ST_MERGED;
               r.index  = INDEX_W'(i);
               r.lo     = tbl_lo[i];
               r.hi     = tbl_hi[i];
               r.flags  = tbl_flags[i];
               r.used   = USED_W'(tbl_count);
               return r;
            end
         end
      end
      if (tbl_count >= TABLE_DEPTH) begin
         r.status = ST_FULL;
         r.used   = USED_W'(tbl_count);
         return r;
      end
      tbl_lo[tbl_count]    = ws;
      tbl_hi[tbl_count]    = we;
      tbl_flags[tbl_count] = wf;
      r.status = ST_APPENDED;
      r.index  = INDEX_W'(tbl_count);
      r.lo     = ws;
      r.hi     = we;
      r.flags  = wf;
      tbl_count++;
      r.used   = USED_W'(tbl_count);
      return r;
   endfunction

   function automatic logic [ADDR_W-1:0] add_clamped(input logic [ADDR_W-1:0] a,
                                                     input logic [ADDR_W-1:0] b);
      logic [ADDR_W:0] sum;
      sum = {1'b0, a} + {1'b0, b};
      return sum[ADDR_W] ? '1 : sum[ADDR_W-1:0];
   endfunction

   function automatic logic [ADDR_W-1:0] sub_clamped(input logic [ADDR_W-1:0] a,
                                                     input logic [ADDR_W-1:0] b);
      return (a < b) ? '0 : a - b;
   endfunction

   function automatic logic [ADDR_W-1:0] random_addr();
      return {$urandom, $urandom};
   endfunction

   function automatic logic [FLAGS_W-1:0] pick_flags();
      case ($urandom_range(0, 5))
         0: return '0;
         1: return '1;
         2: return 32'h0000_0001;
         3: return 32'h8000_0000;
         default: return $urandom;
      endcase
   endfunction

   // Mostly short spans so that windows cluster, with a few huge ones.
   function automatic logic [ADDR_W-1:0] random_span();
      case ($urandom_range(0, 9))
         0: return random_addr();
         1: return {32'h0, $urandom};
         default: return 64'($urandom_range(0, 64));
      endcase
   endfunction

   // Sends one command; between bursts of random length the sender may idle.
   task automatic issue_table_op(input logic op, input logic [ADDR_W-1:0] ws,
                                 input logic [ADDR_W-1:0] we, input logic [FLAGS_W-1:0] wf,
                                 input logic merge, input logic [INDEX_W-1:0] ridx);
      int gap;
      if (burst_left == 0) begin
         burst_left = ($urandom_range(0, 7) == 0) ? 40 : $urandom_range(1, 12);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 24);
         if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      start            <= 1'b1;
      req_opcode       <= op;
      req_window_start <= ws;
      req_window_end   <= we;
      req_window_flags <= wf;
      req_allow_merge  <= merge;
      req_read_index   <= ridx;
      do @(posedge clock); while (busy !== 1'b0);
      pending_replies.push_back(predict_table_op(op, ws, we, wf, merge, ridx));
   endtask

   task automatic report_failure(input string what, input table_reply_type want,
                                 input table_reply_type got);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("%s: status %0d/%0d index %0d/%0d start %h/%h end %h/%h flags %h/%h used %0d/%0d",
                  what, want.status, got.status, want.index, got.index, want.lo, got.lo,
                  want.hi, got.hi, want.flags, got.flags, want.used, got.used);
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_strobe === 1'b1) begin
         if (pending_replies.size() == 0) begin
            report_failure("unexpected result (expected/actual)", '0, seen_reply);
         end else begin
            oldest_reply = pending_replies.pop_front();
            if (seen_reply !== oldest_reply)
               report_failure("wrong result (expected/actual)", oldest_reply, seen_reply);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("address_window_merge_table_core: mismatch");
         $finish;
      end
   end

   task automatic test_empty_table_reads();
      issue_table_op(OP_READ, '1, '1, '1, 1'b1, 4'd0);
      issue_table_op(OP_READ, '0, '0, '0, 1'b0, 4'd15);
   endtask

   task automatic test_invalid_windows();
      issue_table_op(OP_UPDATE, 64'd1, 64'd0, '0, 1'b1, 4'd0);
      issue_table_op(OP_UPDATE, '1, '1, '1, 1'b0, 4'd15);
      issue_table_op(OP_UPDATE, 64'h8000_0000_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF,
                     32'h1234_5678, 1'b1, 4'd7);
   endtask

   task automatic test_append_and_merge();
      issue_table_op(OP_UPDATE, 64'd0, 64'd0, '0, 1'b0, 4'd0);
      issue_table_op(OP_UPDATE, 64'd1, 64'd1, '0, 1'b1, 4'd0);
      // A gap of one address keeps this window apart.
      issue_table_op(OP_UPDATE, 64'd3, 64'd4, '0, 1'b1, 4'd0);
      // Touches both entries; the lower index wins.
      issue_table_op(OP_UPDATE, 64'd2, 64'd2, '0, 1'b1, 4'd0);
      issue_table_op(OP_UPDATE, 64'd5, 64'd9, 32'd1, 1'b1, 4'd0);
      issue_table_op(OP_UPDATE, 64'd2, 64'd3, '0, 1'b0, 4'd0);
      issue_table_op(OP_READ, '0, '0, '0, 1'b0, 4'd0);
      issue_table_op(OP_READ, '0, '0, '0, 1'b0, 4'd3);
      issue_table_op(OP_READ, '0, '0, '0, 1'b0, 4'd4);
   endtask

   task automatic test_top_of_address_space();
      issue_table_op(OP_UPDATE, 64'hFFFF_FFFF_FFFF_FFF0, '1, '1, 1'b1, 4'd0);
      issue_table_op(OP_UPDATE, 64'hFFFF_FFFF_FFFF_FFE0, 64'hFFFF_FFFF_FFFF_FFEF, '1, 1'b1,
                     4'd0);
      issue_table_op(OP_UPDATE, 64'hFFFF_FFFF_FFFF_FFFE, 64'hFFFF_FFFF_FFFF_FFFE, '1, 1'b1,
                     4'd0);
      issue_table_op(OP_UPDATE, '0, '1, 32'h5A5A_A5A5, 1'b0, 4'd0);
      issue_table_op(OP_UPDATE, 64'd7, 64'd7, 32'h5A5A_A5A5, 1'b1, 4'd0);
      issue_table_op(OP_READ, '0, '0, '0, 1'b0, 4'd4);
   endtask

   // Most updates are aimed at an existing entry: overlapping, abutting or just missing it.
   task automatic test_random_traffic(input int count);
      logic [ADDR_W-1:0]  lo;
      logic [ADDR_W-1:0]  hi;
      logic [ADDR_W-1:0]  span;
      logic [FLAGS_W-1:0] fl;
      int                 kind;
      int                 k;
      for (int n = 0; n < count; n++) begin
         kind = $urandom_range(0, 99);
         span = random_span();
         fl   = pick_flags();
         if (kind < 18) begin
            issue_table_op(OP_READ, random_addr(), random_addr(), $urandom,
                           1'($urandom), 4'($urandom));
         end else if (kind < 26) begin
            lo = random_addr();
            hi = random_addr();
            if (lo == hi) hi = lo ^ 64'd1;
            if ($urandom_range(0, 2) == 0) lo = '1;
            else if (lo < hi) {lo, hi} = {hi, lo};
            issue_table_op(OP_UPDATE, lo, hi, fl, 1'($urandom), 4'($urandom));
         end else begin
            if (kind < 85 && tbl_count > 0) begin
               k = $urandom_range(0, tbl_count - 1);
               if ($urandom_range(0, 5) != 0) fl = tbl_flags[k];
               case ($urandom_range(0, 4))
                  0: begin
                     lo = sub_clamped(tbl_lo[k], span);
                     hi = add_clamped(tbl_lo[k], 64'($urandom_range(0, 3)));
                  end
                  1: begin
                     hi = (tbl_lo[k] == '0) ? '0 : tbl_lo[k] - 1;
                     lo = sub_clamped(hi, span);
                  end
                  2: begin
                     lo = (tbl_hi[k] == '1) ? tbl_hi[k] - 1 : tbl_hi[k] + 1;
                     hi = add_clamped(lo, span);
                  end
                  3: begin
                     lo = (tbl_hi[k] > 64'hFFFF_FFFF_FFFF_FFFC) ? tbl_hi[k] : tbl_hi[k] + 2;
                     hi = add_clamped(lo, span);
                  end
                  default: begin
                     hi = (tbl_lo[k] < 2) ? tbl_lo[k] : tbl_lo[k] - 2;
                     lo = sub_clamped(hi, span);
                  end
               endcase
            end else begin
               case ($urandom_range(0, 2))
                  0: lo = random_addr();
                  1: lo = 64'($urandom_range(0, 4096));
                  default: lo = '1 - 64'($urandom_range(0, 4096));
               endcase
               hi = add_clamped(lo, span);
            end
            issue_table_op(OP_UPDATE, lo, hi, fl, ($urandom_range(0, 3) != 0), 4'($urandom));
         end
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      test_empty_table_reads();
      test_invalid_windows();
      test_append_and_merge();
      test_top_of_address_space();
      test_random_traffic(RANDOM_ITEMS);
      start <= 1'b0;
      while (pending_replies.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && pending_replies.size() == 0)
         $display("address_window_merge_table_core: match");
      else
         $display("address_window_merge_table_core: mismatch");
      $finish;
   end

endmodule
